@@ rtl/tfs_pkg.sv @@
// ----------------------------------------------------------------------------
// tfs_pkg: shared types and constants for the 2D transform stack
// Request and status codes, sequencer states and Q16.16 saturating helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package tfs_pkg;

	// Q16.16 constants
	localparam logic signed [31:0] Q_ONE = 32'sh0001_0000;
	localparam logic signed [31:0] Q_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;

	// request codes
	localparam logic [2:0] REQ_PUSH  = 3'd0;
	localparam logic [2:0] REQ_POP   = 3'd1;
	localparam logic [2:0] REQ_TADD  = 3'd2;
	localparam logic [2:0] REQ_SCALE = 3'd3;
	localparam logic [2:0] REQ_ANGLE = 3'd4;

	// status codes
	localparam logic [1:0] STAT_OK        = 2'd0;
	localparam logic [1:0] STAT_POP_BASE  = 2'd1;
	localparam logic [1:0] STAT_PUSH_FULL = 2'd2;
	localparam logic [1:0] STAT_SAT       = 2'd3;

	// sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_UPDATE,
		ST_TADD,
		ST_PREP,
		ST_WALK,
		ST_DRAIN,
		ST_FIN
	} state_t;

	// four multiplier slots per level
	typedef enum logic [1:0] {
		PH_SX,
		PH_SY,
		PH_TX,
		PH_TY
	} phase_t;

	// saturated value with overflow flag
	typedef struct packed {
		logic signed [31:0] val;
		logic               sat;
	} qsat_t;

	// store write request: y in the upper half, x in the lower half
	typedef struct packed {
		logic        en;
		logic [63:0] data;
	} st_wr_t;

	// floor(p / 2^16), saturated to 32 bits
	function automatic qsat_t q_floor_sat(input logic signed [63:0] p);
		logic signed [47:0] q;
		qsat_t r;
		q = p[63:16];
		r.sat = !((&q[47:31]) || !(|q[47:31]));
		if (r.sat) begin
			r.val = q[47] ? Q_MIN : Q_MAX;
		end else begin
			r.val = q[31:0];
		end
		return r;
	endfunction

	// a + b, saturated to 32 bits
	function automatic qsat_t q_add_sat(input logic signed [31:0] a, input logic signed [31:0] b);
		logic signed [32:0] s;
		qsat_t r;
		s = {a[31], a} + {b[31], b};
		r.sat = (s[32] != s[31]);
		if (r.sat) begin
			r.val = s[32] ? Q_MIN : Q_MAX;
		end else begin
			r.val = s[31:0];
		end
		return r;
	endfunction

endpackage

`default_nettype wire

@@ rtl/tfs_qmul.sv @@
// ----------------------------------------------------------------------------
// tfs_qmul: shared Q16.16 multiplier
// 32x32 signed product registered, then floor shift and saturation.
// ----------------------------------------------------------------------------
`default_nettype none

module tfs_qmul (
	input  wire logic                clk,
	input  wire logic signed [31:0]  a,
	input  wire logic signed [31:0]  b,
	output tfs_pkg::qsat_t           res
);

	logic signed [63:0] prod_s1;

	// product register
	always_ff @(posedge clk) begin
		prod_s1 <= a * b;
	end

	// floor to Q16.16 and clamp
	assign res = tfs_pkg::q_floor_sat(prod_s1);

endmodule

`default_nettype wire

@@ rtl/tfs_store.sv @@
// ----------------------------------------------------------------------------
// tfs_store: per-level (x,y) store
// One write port, one registered read port. The base entry has no
// reset value; a flag tells the user that the base has not been written yet.
// ----------------------------------------------------------------------------
`default_nettype none

module tfs_store #(
	parameter  int DEPTH = 16,
	localparam int AW    = $clog2(DEPTH)
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire tfs_pkg::st_wr_t wr,
	input  wire logic [AW-1:0]   wr_addr,
	input  wire logic [AW-1:0]   rd_addr,
	output logic      [63:0]     rd_data,
	output logic                 rd_base_fresh
);

	logic [63:0] mem [DEPTH];
	logic        base_written_q;
	logic        rd_base_q;

	// write port
	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr_addr] <= wr.data;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rd_data <= mem[rd_addr];
	end

	// base entry tracking
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_written_q <= 1'b0;
			rd_base_q      <= 1'b0;
		end else begin
			rd_base_q <= (rd_addr == '0);
			if (wr.en && (wr_addr == '0)) begin
				base_written_q <= 1'b1;
			end
		end
	end

	assign rd_base_fresh = rd_base_q && !base_written_q;

endmodule

`default_nettype wire

@@ rtl/transform_stack_2d.sv @@
// Sequence: an accepted start runs update, translate add (for that request
// only), prep, a walk over the levels live after the command, drain, finish.
// Throughput: the next start is taken in the strobe cycle; the walk is set by
// one shared multiplier doing four multiplications per level.
// Reset (arst_n low, asynchronous): one base level at zero translation and
// unit scale, angle zero, no strobe. done cannot be stalled by the receiver.
// ----------------------------------------------------------------------------
// transform_stack_2d: 2D draw-transform stack
// Per-level translation and scale with a global angle; every command returns
// screen position, screen scale, angle, top translation and status.
// ----------------------------------------------------------------------------
`default_nettype none

module transform_stack_2d #(
	parameter int MAX_DEPTH = 16
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	output logic                    busy,
	input  wire logic        [2:0]  req_type,
	input  wire logic signed [31:0] arg_x,
	input  wire logic signed [31:0] arg_y,
	input  wire logic signed [31:0] angle_value,
	output logic                    done,
	output logic signed [31:0]      screen_x,
	output logic signed [31:0]      screen_y,
	output logic signed [31:0]      screen_scale_x,
	output logic signed [31:0]      screen_scale_y,
	output logic signed [31:0]      screen_angle,
	output logic signed [31:0]      relative_x,
	output logic signed [31:0]      relative_y,
	output logic        [1:0]       status
);

	localparam int LVL_W = $clog2(MAX_DEPTH + 1);
	localparam int IDX_W = $clog2(MAX_DEPTH);
	localparam int ACC_W = 33 + IDX_W;

	// control state
	tfs_pkg::state_t    state_q, state_d;
	tfs_pkg::phase_t    phase_q;
	logic [LVL_W-1:0]   level_q;
	logic [IDX_W-1:0]   idx_q;
	logic signed [31:0] angle_q;
	logic               done_q;

	// command beat and working registers
	logic        [2:0]       req_q;
	logic signed [31:0]      ax_q, ay_q, ang_q;
	logic signed [31:0]      px_q, py_q;
	logic signed [ACC_W-1:0] sum_x_q, sum_y_q;
	logic                    sat_q;
	logic        [1:0]       refused_q;
	logic signed [31:0]      rel_x_q, rel_y_q;

	// result registers
	logic signed [31:0] scr_x_q, scr_y_q, scl_x_q, scl_y_q, ang_out_q, rx_q, ry_q;
	logic        [1:0]  status_q;

	// store and multiplier hookup
	tfs_pkg::st_wr_t    tr_wr, sc_wr;
	logic [IDX_W-1:0]   tr_waddr, sc_waddr, rd_addr;
	logic [63:0]        tr_rd, sc_rd;
	logic               tr_fresh, sc_fresh;
	logic signed [31:0] tr_x, tr_y, sc_x, sc_y;
	logic signed [31:0] mul_a, mul_b;
	tfs_pkg::qsat_t     mres, tadd_x, tadd_y;

	// misc decode
	logic                    accept;
	logic [LVL_W-1:0]        top_lvl;
	logic [IDX_W-1:0]        top_idx;
	logic                    full, at_base, is_last;
	logic signed [ACC_W-1:0] mres_ext;
	logic [ACC_W-32:0]       hi_x, hi_y;
	logic                    ovf_x, ovf_y;

	assign busy    = (state_q != tfs_pkg::ST_IDLE);
	assign accept  = start && !busy;
	assign top_lvl = level_q - LVL_W'(1);
	assign top_idx = top_lvl[IDX_W-1:0];
	assign full    = (level_q == LVL_W'(MAX_DEPTH));
	assign at_base = (level_q == LVL_W'(1));
	assign is_last = ((LVL_W'(idx_q) + LVL_W'(1)) == level_q);

	// base entry reads as its reset value until first written
	assign tr_x = tr_fresh ? 32'sd0 : tr_rd[31:0];
	assign tr_y = tr_fresh ? 32'sd0 : tr_rd[63:32];
	assign sc_x = sc_fresh ? tfs_pkg::Q_ONE : sc_rd[31:0];
	assign sc_y = sc_fresh ? tfs_pkg::Q_ONE : sc_rd[63:32];

	assign tadd_x   = tfs_pkg::q_add_sat(tr_x, ax_q);
	assign tadd_y   = tfs_pkg::q_add_sat(tr_y, ay_q);
	assign mres_ext = {{(ACC_W-32){mres.val[31]}}, mres.val};

	// final sum clamp
	assign hi_x  = sum_x_q[ACC_W-1:31];
	assign hi_y  = sum_y_q[ACC_W-1:31];
	assign ovf_x = !((&hi_x) || !(|hi_x));
	assign ovf_y = !((&hi_y) || !(|hi_y));

	tfs_store #(.DEPTH(MAX_DEPTH)) u_tr_store (
		.clk          (clk),
		.arst_n       (arst_n),
		.wr           (tr_wr),
		.wr_addr      (tr_waddr),
		.rd_addr      (rd_addr),
		.rd_data      (tr_rd),
		.rd_base_fresh(tr_fresh)
	);

	tfs_store #(.DEPTH(MAX_DEPTH)) u_sc_store (
		.clk          (clk),
		.arst_n       (arst_n),
		.wr           (sc_wr),
		.wr_addr      (sc_waddr),
		.rd_addr      (rd_addr),
		.rd_data      (sc_rd),
		.rd_base_fresh(sc_fresh)
	);

	tfs_qmul u_qmul (
		.clk(clk),
		.a  (mul_a),
		.b  (mul_b),
		.res(mres)
	);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			tfs_pkg::ST_IDLE: begin
				if (start) state_d = tfs_pkg::ST_UPDATE;
			end
			tfs_pkg::ST_UPDATE: begin
				state_d = (req_q == tfs_pkg::REQ_TADD) ? tfs_pkg::ST_TADD : tfs_pkg::ST_PREP;
			end
			tfs_pkg::ST_TADD:  state_d = tfs_pkg::ST_PREP;
			tfs_pkg::ST_PREP:  state_d = tfs_pkg::ST_WALK;
			tfs_pkg::ST_WALK: begin
				if ((phase_q == tfs_pkg::PH_TY) && is_last) state_d = tfs_pkg::ST_DRAIN;
			end
			tfs_pkg::ST_DRAIN: state_d = tfs_pkg::ST_FIN;
			tfs_pkg::ST_FIN:   state_d = tfs_pkg::ST_IDLE;
			default:           state_d = tfs_pkg::ST_IDLE;
		endcase
	end

	// store ports, read address and multiplier operands
	always_comb begin
		tr_wr    = '0;
		sc_wr    = '0;
		tr_waddr = top_idx;
		sc_waddr = top_idx;
		rd_addr  = idx_q;
		mul_a    = px_q;
		mul_b    = sc_x;
		unique case (state_q)
			tfs_pkg::ST_UPDATE: begin
				rd_addr = top_idx;
				if ((req_q == tfs_pkg::REQ_PUSH) && !full) begin
					tr_wr.en   = 1'b1;
					tr_wr.data = '0;
					sc_wr.en   = 1'b1;
					sc_wr.data = {tfs_pkg::Q_ONE, tfs_pkg::Q_ONE};
					tr_waddr   = level_q[IDX_W-1:0];
					sc_waddr   = level_q[IDX_W-1:0];
				end
				if (req_q == tfs_pkg::REQ_SCALE) begin
					sc_wr.en   = 1'b1;
					sc_wr.data = {ay_q, ax_q};
				end
			end
			tfs_pkg::ST_TADD: begin
				tr_wr.en   = 1'b1;
				tr_wr.data = {tadd_y.val, tadd_x.val};
			end
			tfs_pkg::ST_PREP: begin
				rd_addr = '0;
			end
			tfs_pkg::ST_WALK: begin
				unique case (phase_q)
					tfs_pkg::PH_SX: begin
						mul_a = px_q;
						mul_b = sc_x;
					end
					tfs_pkg::PH_SY: begin
						mul_a = py_q;
						mul_b = sc_y;
					end
					tfs_pkg::PH_TX: begin
						mul_a = tr_x;
						mul_b = px_q;
					end
					tfs_pkg::PH_TY: begin
						mul_a   = tr_y;
						mul_b   = py_q;
						// next level lands in the read register for its first slot
						rd_addr = idx_q + IDX_W'(1);
					end
					default: ;
				endcase
			end
			default: ;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tfs_pkg::ST_IDLE;
			phase_q <= tfs_pkg::PH_SX;
			level_q <= LVL_W'(1);
			idx_q   <= '0;
			angle_q <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= (state_q == tfs_pkg::ST_FIN);
			if (accept) begin
				phase_q <= tfs_pkg::PH_SX;
				idx_q   <= '0;
			end
			// stack and angle update
			if (state_q == tfs_pkg::ST_UPDATE) begin
				if ((req_q == tfs_pkg::REQ_PUSH) && !full) level_q <= level_q + LVL_W'(1);
				if ((req_q == tfs_pkg::REQ_POP) && !at_base) level_q <= level_q - LVL_W'(1);
				if (req_q == tfs_pkg::REQ_ANGLE) angle_q <= ang_q;
			end
			// walk slot sequencing
			if (state_q == tfs_pkg::ST_WALK) begin
				unique case (phase_q)
					tfs_pkg::PH_SX: phase_q <= tfs_pkg::PH_SY;
					tfs_pkg::PH_SY: phase_q <= tfs_pkg::PH_TX;
					tfs_pkg::PH_TX: phase_q <= tfs_pkg::PH_TY;
					tfs_pkg::PH_TY: begin
						phase_q <= tfs_pkg::PH_SX;
						idx_q   <= idx_q + IDX_W'(1);
					end
					default: phase_q <= tfs_pkg::PH_SX;
				endcase
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (accept) begin
			req_q     <= req_type;
			ax_q      <= arg_x;
			ay_q      <= arg_y;
			ang_q     <= angle_value;
			sat_q     <= 1'b0;
			refused_q <= tfs_pkg::STAT_OK;
			px_q      <= tfs_pkg::Q_ONE;
			py_q      <= tfs_pkg::Q_ONE;
			sum_x_q   <= '0;
			sum_y_q   <= '0;
		end
		unique case (state_q)
			tfs_pkg::ST_UPDATE: begin
				if ((req_q == tfs_pkg::REQ_PUSH) && full) refused_q <= tfs_pkg::STAT_PUSH_FULL;
				if ((req_q == tfs_pkg::REQ_POP) && at_base) refused_q <= tfs_pkg::STAT_POP_BASE;
			end
			tfs_pkg::ST_TADD: begin
				sat_q <= sat_q | tadd_x.sat | tadd_y.sat;
			end
			tfs_pkg::ST_WALK: begin
				unique case (phase_q)
					tfs_pkg::PH_SX: begin
						// y term of the previous level
						if (idx_q != '0) begin
							sum_y_q <= sum_y_q + mres_ext;
							sat_q   <= sat_q | mres.sat;
						end
					end
					tfs_pkg::PH_SY: begin
						px_q  <= mres.val;
						sat_q <= sat_q | mres.sat;
					end
					tfs_pkg::PH_TX: begin
						py_q  <= mres.val;
						sat_q <= sat_q | mres.sat;
					end
					tfs_pkg::PH_TY: begin
						sum_x_q <= sum_x_q + mres_ext;
						sat_q   <= sat_q | mres.sat;
						// last level visited is the top
						rel_x_q <= tr_x;
						rel_y_q <= tr_y;
					end
					default: ;
				endcase
			end
			tfs_pkg::ST_DRAIN: begin
				sum_y_q <= sum_y_q + mres_ext;
				sat_q   <= sat_q | mres.sat;
			end
			tfs_pkg::ST_FIN: begin
				scr_x_q   <= ovf_x ? (sum_x_q[ACC_W-1] ? tfs_pkg::Q_MIN : tfs_pkg::Q_MAX)
				                   : sum_x_q[31:0];
				scr_y_q   <= ovf_y ? (sum_y_q[ACC_W-1] ? tfs_pkg::Q_MIN : tfs_pkg::Q_MAX)
				                   : sum_y_q[31:0];
				scl_x_q   <= px_q;
				scl_y_q   <= py_q;
				ang_out_q <= angle_q;
				rx_q      <= rel_x_q;
				ry_q      <= rel_y_q;
				if (refused_q != tfs_pkg::STAT_OK) begin
					status_q <= refused_q;
				end else if (sat_q || ovf_x || ovf_y) begin
					status_q <= tfs_pkg::STAT_SAT;
				end else begin
					status_q <= tfs_pkg::STAT_OK;
				end
			end
			default: ;
		endcase
	end

	assign done           = done_q;
	assign screen_x       = scr_x_q;
	assign screen_y       = scr_y_q;
	assign screen_scale_x = scl_x_q;
	assign screen_scale_y = scl_y_q;
	assign screen_angle   = ang_out_q;
	assign relative_x     = rx_q;
	assign relative_y     = ry_q;
	assign status         = status_q;

`ifndef SYNTHESIS
	// strobe lasts one cycle and comes with the block free again
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy && !$past(done))
		else $error("done strobe longer than one cycle or while busy");

	// an accepted beat makes the block busy
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted beat did not start the sequencer");

	// live level count stays within the stack
	a_level_range: assert property (@(posedge clk) disable iff (!arst_n)
		(level_q != '0) && (level_q <= LVL_W'(MAX_DEPTH)))
		else $error("level count out of range");
`endif

endmodule

`default_nettype wire
